### design/cdrf_pkg.sv
`default_nettype none

package cdrf_pkg;

   localparam int DEPTH_DEF        = 16;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int TIMER_BITS_DEF   = 16;

   // Fixed widths of the request and response words.
   localparam int PAYLOAD_W = 32;
   localparam int DURATION_W = 16;
   localparam int COUNT_W    = 5;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_TICK    = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_COUNT = 1'b1
   } state_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [PAYLOAD_W-1:0]    payload;
      logic [DURATION_W-1:0]   duration;
   } req_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0]    out_payload;
      logic [DURATION_W-1:0]   out_duration;
      logic [COUNT_W-1:0]      expired_count;
      logic [COUNT_W-1:0]      occupancy;
      logic                    not_empty;
      logic                    error;
   } rsp_type;

   // Broadcast controls for the row of cells.
   typedef struct packed {
      logic load;
      logic shift;
      logic tick;
      logic clear;
      logic hit_shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### design/cdrf_cell.sv
`default_nettype none

module cdrf_cell #(
   parameter int INDEX        = 0,
   parameter int CNT_W        = $clog2(cdrf_pkg::DEPTH_DEF + 1),
   parameter int PAYLOAD_BITS = cdrf_pkg::PAYLOAD_BITS_DEF,
   parameter int TIMER_BITS   = cdrf_pkg::TIMER_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cdrf_pkg::cell_ctrl_type     ctrl,
   input  wire logic [CNT_W-1:0]            count,
   input  wire logic [PAYLOAD_BITS-1:0]     load_payload,
   input  wire logic [TIMER_BITS-1:0]       load_duration,
   input  wire logic [PAYLOAD_BITS-1:0]     nb_payload,
   input  wire logic [TIMER_BITS-1:0]       nb_duration,
   input  wire logic [TIMER_BITS-1:0]       nb_remaining,
   input  wire logic                        nb_hit,
   output logic [PAYLOAD_BITS-1:0]          payload,
   output logic [TIMER_BITS-1:0]            duration,
   output logic [TIMER_BITS-1:0]            remaining,
   output logic                             hit
);
   import cdrf_pkg::*;

   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [TIMER_BITS-1:0]   duration_ff, duration_in;
   logic [TIMER_BITS-1:0]   remaining_ff, remaining_in;
   logic                    hit_ff, hit_in;
   logic                    selected;

   assign selected = (count == CNT_W'(INDEX));

   always_comb begin
      payload_in   = payload_ff;
      duration_in  = duration_ff;
      remaining_in = remaining_ff;
      hit_in       = hit_ff;
      if (ctrl.clear) begin
         remaining_in = '0;
      end else if (ctrl.load && selected) begin
         payload_in   = load_payload;
         duration_in  = load_duration;
         remaining_in = load_duration;
      end else if (ctrl.shift) begin
         // Stored entries move one cell to the head; the far end brings in a stopped timer.
         payload_in   = nb_payload;
         duration_in  = nb_duration;
         remaining_in = nb_remaining;
      end else if (ctrl.tick) begin
         // Timers of empty cells are always zero, so they neither count nor expire.
         hit_in = (remaining_ff == TIMER_BITS'(1));
         if (remaining_ff != '0) begin
            remaining_in = remaining_ff - TIMER_BITS'(1);
         end
      end else if (ctrl.hit_shift) begin
         hit_in = nb_hit;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff  <= payload_in;
      duration_ff <= duration_in;
      if (reset) begin
         remaining_ff <= '0;
         hit_ff       <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         hit_ff       <= hit_in;
      end
   end

   assign payload   = payload_ff;
   assign duration  = duration_ff;
   assign remaining = remaining_ff;
   assign hit       = hit_ff;

endmodule

`default_nettype wire

### design/countdown_request_fifo_unit.sv
`default_nettype none
// Enqueue, dequeue and clear answer in the cycle after start and accept a new word every
// cycle while busy is low. Tick answers once the expiry flags of the cells have shifted out
// of the head cell one per cycle and been counted there; busy is high while that runs.
// Reset (synchronous) empties the queue and stops every timer; stored payloads and
// durations are not cleared. Results are strobed for one cycle and cannot be stalled.
module countdown_request_fifo_unit #(
   parameter int DEPTH        = cdrf_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BITS = cdrf_pkg::PAYLOAD_BITS_DEF,
   parameter int TIMER_BITS   = cdrf_pkg::TIMER_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cdrf_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output cdrf_pkg::rsp_type      rsp_data
);
   import cdrf_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;
   cell_ctrl_type     ctrl;
   logic              accept;
   logic [CNT_W-1:0]  expired_total;

   logic [PAYLOAD_BITS-1:0] load_payload;
   logic [TIMER_BITS-1:0]   load_duration;

   logic [PAYLOAD_BITS-1:0] pay_w [DEPTH+1];
   logic [TIMER_BITS-1:0]   dur_w [DEPTH+1];
   logic [TIMER_BITS-1:0]   rem_w [DEPTH+1];
   logic                    hit_w [DEPTH+1];

   assign load_payload  = PAYLOAD_BITS'(req_data.payload);
   assign load_duration = TIMER_BITS'(req_data.duration);

   // Past the last cell: a stopped timer and no expiry.
   assign pay_w[DEPTH] = '0;
   assign dur_w[DEPTH] = '0;
   assign rem_w[DEPTH] = '0;
   assign hit_w[DEPTH] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cdrf_cell #(
         .INDEX        (i),
         .CNT_W        (CNT_W),
         .PAYLOAD_BITS (PAYLOAD_BITS),
         .TIMER_BITS   (TIMER_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .count         (count_ff),
         .load_payload  (load_payload),
         .load_duration (load_duration),
         .nb_payload    (pay_w[i+1]),
         .nb_duration   (dur_w[i+1]),
         .nb_remaining  (rem_w[i+1]),
         .nb_hit        (hit_w[i+1]),
         .payload       (pay_w[i]),
         .duration      (dur_w[i]),
         .remaining     (rem_w[i]),
         .hit           (hit_w[i])
      );
   end

   assign accept        = start && (state_ff == ST_IDLE);
   assign expired_total = acc_ff + CNT_W'(hit_w[0]);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      ctrl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_ENQUEUE: begin
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        rsp_in.error = 1'b1;
                     end else begin
                        ctrl.load = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_in.error = 1'b1;
                     end else begin
                        rsp_in.out_payload  = PAYLOAD_W'(pay_w[0]);
                        rsp_in.out_duration = DURATION_W'(dur_w[0]);
                        ctrl.shift = 1'b1;
                        count_in   = count_ff - CNT_W'(1);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  OP_TICK: begin
                     ctrl.tick = 1'b1;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        steps_in = count_ff;
                        acc_in   = '0;
                        state_in = ST_COUNT;
                     end
                  end
                  OP_CLEAR: begin
                     ctrl.clear    = 1'b1;
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
               rsp_in.occupancy = COUNT_W'(count_in);
               rsp_in.not_empty = (count_in != '0);
            end
         end
         ST_COUNT: begin
            // Held entries sit in the first count cells, so count shifts see every expiry.
            ctrl.hit_shift = 1'b1;
            acc_in   = expired_total;
            steps_in = steps_ff - CNT_W'(1);
            if (steps_ff == CNT_W'(1)) begin
               rsp_strobe_in        = 1'b1;
               rsp_in.expired_count = COUNT_W'(expired_total);
               rsp_in.occupancy     = COUNT_W'(count_ff);
               rsp_in.not_empty     = (count_ff != '0);
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      steps_ff <= steps_in;
      acc_ff   <= acc_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff == ST_COUNT);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above queue depth");

   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode != OP_TICK) |=> rsp_strobe)
      else $error("missing one-cycle response");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff != '0 && steps_ff != '0))
      else $error("expiry count running on an empty queue");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobed while counting");

endmodule

`default_nettype wire
